// ----- src/secded_pkg.sv -----
package secded_pkg;

    // Field widths of one word.
    localparam int WORD_BITS  = 64;
    localparam int ECC_BITS   = 8;
    localparam int HAM_BITS   = 7;
    localparam int WIDTH_BITS = 7;

    // Request kinds.
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_REPAIR = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } status_t;

    // Mask k marks the data bits whose code position has bit k set.
    typedef logic [WORD_BITS-1:0] ham_mask_array_t [HAM_BITS];

    localparam ham_mask_array_t HAM_MASK = '{
        64'hab55555556aaad5b,
        64'hcd9999999b33366d,
        64'hf1e1e1e1e3c3c78e,
        64'h01fe01fe03fc07f0,
        64'h01fffe0003fff800,
        64'h01fffffffc000000,
        64'hfe00000000000000
    };

    // One finished result word.
    typedef struct packed {
        logic [WORD_BITS-1:0] data_out;
        logic [ECC_BITS-1:0]  ecc_out;
        status_t              status;
        logic                 ecc_matches;
    } result_t;

    // Number of Hamming parity bits needed for a given data width.
    function automatic logic [2:0] check_bits(input logic [WIDTH_BITS-1:0] w);
        logic [2:0] p;
        if (w == 7'd0) begin
            p = 3'd1;
        end else if (w == 7'd1) begin
            p = 3'd2;
        end else if (w <= 7'd4) begin
            p = 3'd3;
        end else if (w <= 7'd11) begin
            p = 3'd4;
        end else if (w <= 7'd26) begin
            p = 3'd5;
        end else if (w <= 7'd57) begin
            p = 3'd6;
        end else begin
            p = 3'd7;
        end
        return p;
    endfunction

endpackage

// ----- src/secded_encode_and_repair_unit.sv -----
// SECDED encode and check-and-repair unit for up to 64 data bits. Each input
// word is either encoded (kind 0) into an extended Hamming check byte or
// checked against a received check byte (kind 1), with a single error in the
// data or the check byte corrected and double or out-of-range errors flagged
// as uncorrectable. The unit accepts one word every cycle when the result side
// is not stalled. A word is held in the input register, and the parity,
// syndrome and repair logic then loads its result into the output register,
// from which it is presented on the result side. Backpressure
// on the result side stalls both registers. The protected width is written
// through cfg_wr_en and cfg_wr_data, resets to DATA_WIDTH, and values above
// DATA_WIDTH act as DATA_WIDTH; write it only while no word is in flight.
module secded_encode_and_repair_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [secded_pkg::WIDTH_BITS-1:0]   cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [secded_pkg::WORD_BITS-1:0]    s_data_in,
    input  logic [secded_pkg::ECC_BITS-1:0]     s_ecc_in,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [secded_pkg::WORD_BITS-1:0]    m_data_out,
    output logic [secded_pkg::ECC_BITS-1:0]     m_ecc_out,
    output logic [1:0]                          m_status,
    output logic                                m_ecc_matches
);

    logic [secded_pkg::WIDTH_BITS-1:0] width_reg;
    logic                              in_valid_reg;
    logic                              in_kind_reg;
    logic [secded_pkg::WORD_BITS-1:0]  in_data_reg;
    logic [secded_pkg::ECC_BITS-1:0]   in_ecc_reg;
    logic                              out_valid_reg;
    secded_pkg::result_t               out_reg;
    secded_pkg::result_t               result_next;
    logic                              out_advance;
    logic                              in_advance;

    // Width register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= secded_pkg::WIDTH_BITS'(DATA_WIDTH);
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    // Pipeline flow: each stage moves when the stage after it can take a word.
    assign out_advance = !out_valid_reg || m_ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_ready     = in_advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_valid) begin
            in_kind_reg <= s_kind;
            in_data_reg <= s_data_in;
            in_ecc_reg  <= s_ecc_in;
        end
    end

    // Encode, syndrome and repair logic.
    secded_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .kind       (in_kind_reg),
        .data_in    (in_data_reg),
        .ecc_in     (in_ecc_reg),
        .width_cfg  (width_reg),
        .result     (result_next)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            out_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data_out    = out_reg.data_out;
    assign m_ecc_out     = out_reg.ecc_out;
    assign m_status      = out_reg.status;
    assign m_ecc_matches = out_reg.ecc_matches;

endmodule

// ----- src/secded_core.sv -----
module secded_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                                kind,
    input  logic [secded_pkg::WORD_BITS-1:0]    data_in,
    input  logic [secded_pkg::ECC_BITS-1:0]     ecc_in,
    input  logic [secded_pkg::WIDTH_BITS-1:0]   width_cfg,
    output secded_pkg::result_t                 result
);

    localparam logic [secded_pkg::WIDTH_BITS-1:0] WIDTH_MAX =
        secded_pkg::WIDTH_BITS'(DATA_WIDTH);

    logic [secded_pkg::WIDTH_BITS-1:0] width_act;
    logic [secded_pkg::WORD_BITS-1:0]  width_mask;
    logic [secded_pkg::WORD_BITS-1:0]  data_masked;
    logic [secded_pkg::HAM_BITS-1:0]   ham;
    logic                              overall;
    logic [secded_pkg::ECC_BITS-1:0]   expected;
    logic [2:0]                        pbits;
    logic [secded_pkg::ECC_BITS-1:0]   pmask_wide;
    logic [secded_pkg::HAM_BITS-1:0]   pmask;
    logic [secded_pkg::HAM_BITS-1:0]   recv_ham;
    logic [secded_pkg::HAM_BITS-1:0]   syn;
    logic                              overall_err;
    logic [secded_pkg::ECC_BITS-1:0]   total;
    logic                              syn_pow2;
    logic [secded_pkg::WORD_BITS-1:0]  flip;
    logic [secded_pkg::ECC_BITS-1:0]   repaired_ecc;

    // Clamp the configured width to what the instance protects.
    assign width_act = (width_cfg > WIDTH_MAX) ? WIDTH_MAX : width_cfg;

    // Mask off the data bits above the active width.
    always_comb begin
        for (int i = 0; i < secded_pkg::WORD_BITS; i++) begin
            width_mask[i] = (secded_pkg::WIDTH_BITS'(i) < width_act);
        end
    end

    assign data_masked = data_in & width_mask;

    // Hamming parity bits and overall parity of the masked data.
    always_comb begin
        for (int k = 0; k < secded_pkg::HAM_BITS; k++) begin
            ham[k] = ^(data_masked & secded_pkg::HAM_MASK[k]);
        end
    end

    assign overall  = (^data_masked) ^ (^ham);
    assign expected = {overall, ham};

    // Syndrome over the parity bits in use.
    assign pbits       = secded_pkg::check_bits(width_act);
    assign pmask_wide  = (8'd1 << pbits) - 8'd1;
    assign pmask       = pmask_wide[secded_pkg::HAM_BITS-1:0];
    assign recv_ham    = ecc_in[secded_pkg::HAM_BITS-1:0] & pmask;
    assign syn         = (ham ^ ecc_in[secded_pkg::HAM_BITS-1:0]) & pmask;
    assign overall_err = (^data_masked) ^ (^recv_ham) ^ ecc_in[secded_pkg::ECC_BITS-1];
    assign total       = {1'b0, width_act} + {5'd0, pbits};
    assign syn_pow2    = (syn != '0) && ((syn & (syn - 7'd1)) == '0);

    // Select the data bit whose code position equals the syndrome.
    always_comb begin
        logic [secded_pkg::HAM_BITS-1:0] pos;
        for (int i = 0; i < secded_pkg::WORD_BITS; i++) begin
            for (int k = 0; k < secded_pkg::HAM_BITS; k++) begin
                pos[k] = secded_pkg::HAM_MASK[k][i];
            end
            flip[i] = width_mask[i] && (syn == pos);
        end
    end

    // Flipping the data bit at position syn moves the Hamming bits by syn.
    assign repaired_ecc = {overall ^ 1'b1 ^ (^syn), ham ^ syn};

    // Decision for one word.
    always_comb begin
        result.data_out    = data_masked;
        result.ecc_out     = ecc_in;
        result.status      = secded_pkg::STATUS_OK;
        result.ecc_matches = (ecc_in == expected);
        priority if (kind == secded_pkg::KIND_ENCODE) begin
            result.ecc_out = expected;
        end else if (width_act == '0) begin
            result.data_out = data_in;
            result.status   = secded_pkg::STATUS_UNCORRECTABLE;
        end else if (syn == '0 && !overall_err) begin
            result.status = secded_pkg::STATUS_OK;
        end else if (syn == '0) begin
            result.ecc_out = expected;
            result.status  = secded_pkg::STATUS_CORRECTED;
        end else if (!overall_err || {1'b0, syn} > total) begin
            result.status = secded_pkg::STATUS_UNCORRECTABLE;
        end else if (syn_pow2) begin
            result.ecc_out = expected;
            result.status  = secded_pkg::STATUS_CORRECTED;
        end else if (flip == '0) begin
            result.status = secded_pkg::STATUS_UNCORRECTABLE;
        end else begin
            result.data_out = data_masked ^ flip;
            result.ecc_out  = repaired_ecc;
            result.status   = secded_pkg::STATUS_CORRECTED;
        end
    end

endmodule

// ----- sim/secded_encode_and_repair_unit_test.sv -----
`timescale 1ns / 100ps

module secded_encode_and_repair_unit_test;

    localparam int DUT_WIDTH = 64;

    // One request word as queued for the driver.
    typedef struct {
        logic                             kind;
        logic [secded_pkg::WORD_BITS-1:0] data;
        logic [secded_pkg::ECC_BITS-1:0]  ecc;
    } request_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [secded_pkg::WIDTH_BITS-1:0] cfg_wr_data = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic                              s_kind = secded_pkg::KIND_ENCODE;
    logic [secded_pkg::WORD_BITS-1:0]  s_data_in = '0;
    logic [secded_pkg::ECC_BITS-1:0]   s_ecc_in = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [secded_pkg::WORD_BITS-1:0]  m_data_out;
    logic [secded_pkg::ECC_BITS-1:0]   m_ecc_out;
    logic [1:0]                        m_status;
    logic                              m_ecc_matches;

    request_t            pending_words[$];
    secded_pkg::result_t expected_words[$];
    int                  width_now = DUT_WIDTH;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    logic                steady;

    // Both sides run without gaps for one stretch of the run.
    assign steady = (cycle_count >= 1000) && (cycle_count < 1600);

    secded_encode_and_repair_unit #(
        .DATA_WIDTH(DUT_WIDTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_in     (s_data_in),
        .s_ecc_in      (s_ecc_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_ecc_out     (m_ecc_out),
        .m_status      (m_status),
        .m_ecc_matches (m_ecc_matches)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Clamp the programmed width and keep only the protected low data bits.
    function automatic int clamp_width(input int w);
        return (w > DUT_WIDTH) ? DUT_WIDTH : w;
    endfunction

    function automatic logic [secded_pkg::WORD_BITS-1:0] width_masked(
        input logic [secded_pkg::WORD_BITS-1:0] d,
        input int w
    );
        return (w >= secded_pkg::WORD_BITS) ? d : (d & ((64'd1 << w) - 64'd1));
    endfunction

    // Check byte of already masked data: XOR of the code positions of set data bits,
    // where data bits skip the power-of-two positions, plus overall parity on top.
    function automatic logic [secded_pkg::ECC_BITS-1:0] check_byte(
        input logic [secded_pkg::WORD_BITS-1:0] md,
        input int w
    );
        logic [secded_pkg::HAM_BITS-1:0] h;
        int pos;
        h = '0;
        pos = 2;
        for (int i = 0; i < w; i++) begin
            pos++;
            while ((pos & (pos - 1)) == 0) pos++;
            if (md[i]) h ^= pos[secded_pkg::HAM_BITS-1:0];
        end
        return {(^md) ^ (^h), h};
    endfunction

    // Expected result of one word at the given programmed width.
    function automatic secded_pkg::result_t secded_predict(
        input logic kind,
        input logic [secded_pkg::WORD_BITS-1:0] data,
        input logic [secded_pkg::ECC_BITS-1:0] ecc,
        input int width_cfg
    );
        secded_pkg::result_t r;
        int w, p, total, idx;
        logic [secded_pkg::WORD_BITS-1:0] md;
        logic [secded_pkg::ECC_BITS-1:0] enc;
        logic [secded_pkg::HAM_BITS-1:0] pmask, syn;
        logic oerr;
        w = clamp_width(width_cfg);
        md = width_masked(data, w);
        enc = check_byte(md, w);
        r.data_out = md;
        r.ecc_out = ecc;
        r.status = secded_pkg::STATUS_OK;
        r.ecc_matches = (ecc == enc);
        if (kind == secded_pkg::KIND_ENCODE) begin
            r.ecc_out = enc;
        end else if (w == 0) begin
            // Nothing is protected: flag it and pass the data through unmasked.
            r.data_out = data;
            r.status = secded_pkg::STATUS_UNCORRECTABLE;
        end else begin
            p = 1;
            while ((1 << p) < w + p + 1) p++;
            pmask = secded_pkg::HAM_BITS'((1 << p) - 1);
            total = w + p;
            syn = (enc[secded_pkg::HAM_BITS-1:0] ^ ecc[secded_pkg::HAM_BITS-1:0]) & pmask;
            oerr = (^md) ^ (^(ecc[secded_pkg::HAM_BITS-1:0] & pmask))
                   ^ ecc[secded_pkg::ECC_BITS-1];
            if (syn == 0) begin
                // Only the overall parity bit is off: rewrite the check byte.
                if (oerr) begin
                    r.ecc_out = enc;
                    r.status = secded_pkg::STATUS_CORRECTED;
                end
            end else if (!oerr || syn > total) begin
                r.status = secded_pkg::STATUS_UNCORRECTABLE;
            end else if ((syn & (syn - 1)) == 0) begin
                r.ecc_out = enc;
                r.status = secded_pkg::STATUS_CORRECTED;
            end else begin
                // Map the code position back to its data bit and flip it.
                idx = 0;
                for (int q = 3; q < syn; q++) begin
                    if ((q & (q - 1)) != 0) idx++;
                end
                if (idx >= w) begin
                    r.status = secded_pkg::STATUS_UNCORRECTABLE;
                end else begin
                    r.data_out = md ^ (64'd1 << idx);
                    r.ecc_out = check_byte(r.data_out, w);
                    r.status = secded_pkg::STATUS_CORRECTED;
                end
            end
        end
        return r;
    endfunction

    // Driver: predict each accepted word, then present the next pending one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_words.push_back(secded_predict(s_kind, s_data_in, s_ecc_in, width_now));
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 10)) begin
                    s_valid   <= 1'b1;
                    s_kind    <= pending_words[0].kind;
                    s_data_in <= pending_words[0].data;
                    s_ecc_in  <= pending_words[0].ecc;
                    void'(pending_words.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        secded_pkg::result_t want;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data_out !== want.data_out) begin
                        $error("data_out: expected %h, got %h", want.data_out, m_data_out);
                        mismatch_count++;
                    end
                    if (m_ecc_out !== want.ecc_out) begin
                        $error("ecc_out: expected %h, got %h", want.ecc_out, m_ecc_out);
                        mismatch_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatch_count++;
                    end
                    if (m_ecc_matches !== want.ecc_matches) begin
                        $error("ecc_matches: expected %b, got %b", want.ecc_matches,
                               m_ecc_matches);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    task automatic queue_word(input logic kind, input logic [secded_pkg::WORD_BITS-1:0] d,
                              input logic [secded_pkg::ECC_BITS-1:0] e);
        request_t req;
        req.kind = kind;
        req.data = d;
        req.ecc  = e;
        pending_words.push_back(req);
    endtask

    // Hold off until every word has been accepted and answered, plus a margin.
    task automatic wait_for_drain();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_width(input int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[secded_pkg::WIDTH_BITS-1:0];
        width_now = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly codewords with zero, one or two flipped bits, plus encodes and noise.
    task automatic queue_random_words(input int count);
        logic [secded_pkg::WORD_BITS-1:0] d;
        logic [secded_pkg::ECC_BITS-1:0] e;
        int w, pick;
        w = clamp_width(width_now);
        @(negedge aclk);
        for (int n = 0; n < count; n++) begin
            d = {$urandom, $urandom};
            if ($urandom_range(9) == 0) d = $urandom_range(1) ? '1 : '0;
            e = check_byte(width_masked(d, w), w);
            pick = $urandom_range(99);
            if (pick < 25) begin
                queue_word(secded_pkg::KIND_ENCODE, d, $urandom_range(1) ? e : 8'($urandom));
            end else if (pick < 40) begin
                queue_word(secded_pkg::KIND_REPAIR, d, e);
            end else if (pick < 65) begin
                if (w > 0 && $urandom_range(4) != 0) d[6'($urandom_range(w - 1))] ^= 1'b1;
                else d[6'($urandom_range(secded_pkg::WORD_BITS - 1))] ^= 1'b1;
                queue_word(secded_pkg::KIND_REPAIR, d, e);
            end else if (pick < 78) begin
                e[3'($urandom_range(secded_pkg::ECC_BITS - 1))] ^= 1'b1;
                queue_word(secded_pkg::KIND_REPAIR, d, e);
            end else if (pick < 90) begin
                e[3'($urandom_range(secded_pkg::ECC_BITS - 1))] ^= 1'b1;
                if (w > 0 && $urandom_range(1)) d[6'($urandom_range(w - 1))] ^= 1'b1;
                else e ^= 8'd1 << $urandom_range(secded_pkg::ECC_BITS - 1);
                queue_word(secded_pkg::KIND_REPAIR, d, e);
            end else begin
                queue_word(secded_pkg::KIND_REPAIR, d, 8'($urandom));
            end
        end
    endtask

    initial begin
        int width_plan[17];
        logic [secded_pkg::WORD_BITS-1:0] a;
        logic [secded_pkg::ECC_BITS-1:0] ga;
        width_plan = '{0, 1, 2, 3, 4, 5, 11, 12, 26, 27, 57, 58, 63, 64, 100, 127, 0};
        a  = 64'h0123456789abcdef;
        ga = check_byte(a, DUT_WIDTH);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset width.
        @(negedge aclk);
        queue_word(secded_pkg::KIND_ENCODE, '0, '0);
        queue_word(secded_pkg::KIND_ENCODE, '1, '1);
        queue_word(secded_pkg::KIND_ENCODE, 64'h1, '0);
        queue_word(secded_pkg::KIND_ENCODE, 64'h8000000000000000,
                   check_byte(64'h8000000000000000, DUT_WIDTH));
        queue_word(secded_pkg::KIND_REPAIR, '1, check_byte('1, DUT_WIDTH));
        queue_word(secded_pkg::KIND_REPAIR, '0, '0);
        queue_word(secded_pkg::KIND_REPAIR, a, ga);
        // Overall parity bit alone flipped.
        queue_word(secded_pkg::KIND_REPAIR, a, ga ^ 8'h80);
        // Single Hamming bits flipped.
        queue_word(secded_pkg::KIND_REPAIR, a, ga ^ 8'h01);
        queue_word(secded_pkg::KIND_REPAIR, a, ga ^ 8'h40);
        // Single data bits flipped at both ends.
        queue_word(secded_pkg::KIND_REPAIR, a ^ 64'h1, ga);
        queue_word(secded_pkg::KIND_REPAIR, a ^ 64'h8000000000000000, ga);
        // Double errors.
        queue_word(secded_pkg::KIND_REPAIR, a ^ 64'h0000000100000010, ga);
        queue_word(secded_pkg::KIND_REPAIR, a ^ 64'h4, ga ^ 8'h80);
        // Syndrome past the last code position with odd overall error.
        queue_word(secded_pkg::KIND_REPAIR, a, ga ^ 8'd100);
        queue_word(secded_pkg::KIND_REPAIR, '0, '1);
        queue_word(secded_pkg::KIND_REPAIR, a, 8'($urandom));
        wait_for_drain();

        // Random words across a spread of widths; the sender holds off between them.
        for (int i = 0; i < 17; i++) begin
            write_width((i == 16) ? $urandom_range(127) : width_plan[i]);
            queue_random_words(105);
            wait_for_drain();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
src/secded_pkg.sv
src/secded_core.sv
src/secded_encode_and_repair_unit.sv
sim/secded_encode_and_repair_unit_test.sv
